// ===== sv/greedy_longest_match_tokenizer_unit_macros.svh =====
// Shared assertion macros for the tokenizer RTL.
`ifndef GREEDY_LONGEST_MATCH_TOKENIZER_UNIT_MACROS_SVH
`define GREEDY_LONGEST_MATCH_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/glmt_pkg.sv =====
package glmt_pkg;

	localparam int KEY_BYTES = 8;

	// input item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TEXT = 1'b1;

	// result kinds
	localparam logic [1:0] RK_MATCH = 2'd0;
	localparam logic [1:0] RK_SKIP  = 2'd1;
	localparam logic [1:0] RK_END   = 2'd2;

	typedef struct packed {
		logic [KEY_BYTES*8-1:0] key;
		logic [3:0]             len;
		logic [15:0]            id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic clear;      // restart the search for a new match
		logic cmp_valid;  // read data from the table is valid this cycle
	} match_ctrl_t;

endpackage

// ===== sv/glmt_in_if.sv =====
interface glmt_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  entry_index;
	logic [63:0] entry_bytes;
	logic [3:0]  entry_length;
	logic [15:0] entry_id;
	logic [7:0]  text_byte;
	logic        text_last;

	modport source (
		output valid, kind, entry_index, entry_bytes, entry_length, entry_id,
			text_byte, text_last,
		input ready
	);
	modport sink (
		input valid, kind, entry_index, entry_bytes, entry_length, entry_id,
			text_byte, text_last,
		output ready
	);
endinterface

// ===== sv/glmt_out_if.sv =====
interface glmt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [15:0] token_id;
	logic [7:0]  skipped_byte;
	logic        last;

	modport source (
		output valid, result_kind, token_id, skipped_byte, last,
		input ready
	);
	modport sink (
		input valid, result_kind, token_id, skipped_byte, last,
		output ready
	);
endinterface

// ===== sv/glmt_ram.sv =====
module glmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/glmt_match.sv =====
module glmt_match #(
	parameter int MAX_TOKEN_BYTES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  glmt_pkg::match_ctrl_t              ctrl,
	input  glmt_pkg::entry_t                   entry,
	input  logic [MAX_TOKEN_BYTES*8-1:0]       lookahead,
	input  logic [$clog2(MAX_TOKEN_BYTES+1)-1:0] count,
	output logic [$clog2(MAX_TOKEN_BYTES+1)-1:0] best_len,
	output logic [15:0]                        best_id
);
	localparam int CW = $clog2(MAX_TOKEN_BYTES + 1);

	logic [CW-1:0] best_len_q;
	logic [15:0]   best_id_q;
	logic          key_eq;
	logic          hit;

	// compare the key bytes that lie inside the entry's length
	always_comb begin
		key_eq = 1'b1;
		for (int j = 0; j < MAX_TOKEN_BYTES; j++) begin
			if ((4'(j) < entry.len) && (entry.key[j*8 +: 8] != lookahead[j*8 +: 8])) begin
				key_eq = 1'b0;
			end
		end
	end

	assign hit = ctrl.cmp_valid && (entry.len != 4'd0)
		&& (entry.len <= 4'(MAX_TOKEN_BYTES))
		&& (entry.len <= 4'(count))
		&& (entry.len > 4'(best_len_q))
		&& key_eq;

	// strictly longer only, so the lowest index wins among equal lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_len_q <= '0;
			best_id_q  <= '0;
		end else if (ctrl.clear) begin
			best_len_q <= '0;
			best_id_q  <= '0;
		end else if (hit) begin
			best_len_q <= CW'(entry.len);
			best_id_q  <= entry.id;
		end
	end

	assign best_len = best_len_q;
	assign best_id  = best_id_q;
endmodule

// ===== sv/greedy_longest_match_tokenizer_unit.sv =====
// Greedy longest-match tokenizer.
// Channels: text_in (sink) carries load items (kind 0) that write one table
// slot, and text bytes (kind 1); tok_out (source) carries match, skip and
// end-of-text results. A transaction completes when valid and ready are high.
// A load gives no result. A text byte that neither fills the lookahead buffer
// nor ends the text gives no result. Every match walks the whole table once
// through the single read port of the table RAM, so a full buffer costs one
// walk per byte and a last byte costs up to MAX_TOKEN_BYTES such walks plus
// one end result.
// Only one item is in work at a time; text_in is ready while the block waits
// for input, even when a result still sits in the output register.
// Reset: after arst_n is released the block clears the table, one slot per
// cycle, for TABLE_ENTRIES cycles, with text_in.ready low.
// A stalled receiver holds the result in the output register; the walk for
// the next result runs on and waits before overwriting it.
module greedy_longest_match_tokenizer_unit #(
	parameter int TABLE_ENTRIES   = 256,
	parameter int MAX_TOKEN_BYTES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	glmt_in_if.sink    text_in,
	glmt_out_if.source tok_out
);
	`include "greedy_longest_match_tokenizer_unit_macros.svh"

	localparam int AW  = $clog2(TABLE_ENTRIES);
	localparam int CW  = $clog2(MAX_TOKEN_BYTES + 1);
	localparam int BW  = MAX_TOKEN_BYTES * 8;
	localparam int IXW = ((AW > 8) ? AW : 8) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_PUT   = 6'b010000,
		ST_END   = 6'b100000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] addr_q;
	logic          rd_v_s1;
	logic          last_mode_q;
	logic [BW-1:0] look_q;
	logic [CW-1:0] cnt_q;

	logic          out_valid_q;
	logic [1:0]    res_kind_q;
	logic [15:0]   res_id_q;
	logic [7:0]    res_byte_q;
	logic          res_last_q;

	logic          in_acc;
	logic          out_free;
	logic          load_in_range;
	logic [IXW-1:0] idx_ext;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	glmt_pkg::entry_t ram_wdata;
	glmt_pkg::entry_t ram_rdata;
	glmt_pkg::match_ctrl_t mctrl;
	logic [CW-1:0] best_len;
	logic [15:0]   best_id;
	logic [CW-1:0] drop;
	logic [CW-1:0] cnt_after;
	logic [CW-1:0] cnt_plus;
	logic          text_needs_match;
	logic          put_go;
	logic          end_go;

	assign in_acc   = text_in.valid && text_in.ready;
	assign out_free = !out_valid_q || tok_out.ready;
	assign idx_ext  = IXW'(text_in.entry_index);
	assign load_in_range = idx_ext < IXW'(TABLE_ENTRIES);

	assign cnt_plus = cnt_q + CW'(1);
	assign text_needs_match = text_in.text_last || (cnt_plus == CW'(MAX_TOKEN_BYTES));

	assign put_go = (state_q == ST_PUT) && out_free;
	assign end_go = (state_q == ST_END) && out_free;

	// a skip drops one byte; a match drops its key length
	assign drop      = (best_len != '0) ? best_len : CW'(1);
	assign cnt_after = cnt_q - drop;

	// table write port: clearing pass, then load items
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (in_acc && (text_in.kind == glmt_pkg::KIND_LOAD) && load_in_range) begin
			ram_we         = 1'b1;
			ram_waddr      = idx_ext[AW-1:0];
			ram_wdata.key  = text_in.entry_bytes;
			ram_wdata.len  = text_in.entry_length;
			ram_wdata.id   = text_in.entry_id;
		end
	end

	glmt_ram #(
		.WIDTH(glmt_pkg::ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		mctrl.cmp_valid = rd_v_s1;
		mctrl.clear = (in_acc && (text_in.kind == glmt_pkg::KIND_TEXT) && text_needs_match)
			|| (put_go && last_mode_q && (cnt_after != '0));
	end

	glmt_match #(
		.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mctrl),
		.entry    (ram_rdata),
		.lookahead(look_q),
		.count    (cnt_q),
		.best_len (best_len),
		.best_id  (best_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			rd_v_s1     <= 1'b0;
			last_mode_q <= 1'b0;
			look_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			if (put_go || end_go) begin
				out_valid_q <= 1'b1;
			end else if (tok_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_acc && (text_in.kind == glmt_pkg::KIND_TEXT)) begin
						look_q      <= look_q | (BW'(text_in.text_byte) << {cnt_q, 3'b000});
						cnt_q       <= cnt_plus;
						last_mode_q <= text_in.text_last;
						if (text_needs_match) begin
							addr_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					// last table word is compared in this cycle
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free) begin
						look_q      <= look_q >> {drop, 3'b000};
						cnt_q       <= cnt_after;
						if (!last_mode_q) begin
							state_q <= ST_IDLE;
						end else if (cnt_after != '0) begin
							addr_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_END;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						look_q      <= '0;
						cnt_q       <= '0;
						last_mode_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (put_go) begin
			res_kind_q <= (best_len != '0) ? glmt_pkg::RK_MATCH : glmt_pkg::RK_SKIP;
			res_id_q   <= (best_len != '0) ? best_id : 16'd0;
			res_byte_q <= (best_len != '0) ? 8'd0 : look_q[7:0];
			res_last_q <= !last_mode_q;
		end else if (end_go) begin
			res_kind_q <= glmt_pkg::RK_END;
			res_id_q   <= 16'd0;
			res_byte_q <= 8'd0;
			res_last_q <= 1'b1;
		end
	end

	assign text_in.ready        = (state_q == ST_IDLE);
	assign tok_out.valid        = out_valid_q;
	assign tok_out.result_kind  = res_kind_q;
	assign tok_out.token_id     = res_id_q;
	assign tok_out.skipped_byte = res_byte_q;
	assign tok_out.last         = res_last_q;

	`GLMT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_TOKEN_BYTES), "lookahead count overflow")
	`GLMT_ASSERT_NOW(a_best_fits, state_q == ST_PUT, best_len <= cnt_q, "match longer than buffer")
	`GLMT_ASSERT_NOW(a_put_nonempty, state_q == ST_PUT, cnt_q != '0, "match on empty buffer")
	`GLMT_ASSERT_NEXT(a_end_empties, end_go, (cnt_q == '0) && out_valid_q, "end result left data")
	`GLMT_ASSERT_NOW(a_kind_legal, out_valid_q, res_kind_q <= glmt_pkg::RK_END, "bad result kind")
endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_ENTRIES   = 256;
	localparam int MAX_TOKEN_BYTES = 8;
	localparam int ITEM_TARGET     = 240;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		bit        kind;
		bit [7:0]  entry_index;
		bit [63:0] entry_bytes;
		bit [3:0]  entry_length;
		bit [15:0] entry_id;
		bit [7:0]  text_byte;
		bit        text_last;
	} tok_item_t;

	typedef struct packed {
		bit [1:0]  rkind;
		bit [15:0] id;
		bit [7:0]  skipped;
		bit        last;
	} token_t;

	typedef struct {
		tok_item_t it;
		bit        typed;
		int        n_typed;
		token_t    typed_res[2];
	} plan_row_t;

	logic clk;
	logic arst_n;

	glmt_in_if  text_ch();
	glmt_out_if token_ch();

	greedy_longest_match_tokenizer_unit #(
		.TABLE_ENTRIES  (TABLE_ENTRIES),
		.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text_in(text_ch),
		.tok_out(token_ch)
	);

	// predictor state: token table and lookahead window
	bit [63:0] slot_key [TABLE_ENTRIES];
	bit [3:0]  slot_len [TABLE_ENTRIES];
	bit [15:0] slot_id  [TABLE_ENTRIES];
	bit [63:0] window_bytes;
	int        window_count;

	token_t new_tokens[$];
	token_t expected_tokens[$];

	int  fault_count;
	int  results_seen;
	int  loads_sent;
	int  bytes_sent;
	int  matches_seen;
	int  skips_seen;
	int  ends_seen;
	int  stalled_cycles;
	bit  quiet_text;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void emit_token(input token_t t);
		new_tokens = {new_tokens, t};
	endfunction

	function automatic void longest_match(input bit last);
		int        best_len;
		int        len;
		bit [15:0] best_id;
		bit [63:0] mask;
		token_t    r;
		best_len = 0;
		best_id = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			len = slot_len[i];
			// strict compare keeps the lowest slot among equal lengths
			if (len == 0 || len > MAX_TOKEN_BYTES || len > window_count || len <= best_len)
				continue;
			mask = (len >= 8) ? '1 : (64'd1 << (8 * len)) - 64'd1;
			if (((slot_key[i] ^ window_bytes) & mask) == '0) begin
				best_len = len;
				best_id = slot_id[i];
			end
		end
		if (best_len > 0) begin
			r = '{rkind: glmt_pkg::RK_MATCH, id: best_id, skipped: 8'd0, last: last};
		end else begin
			r = '{rkind: glmt_pkg::RK_SKIP, id: 16'd0, skipped: window_bytes[7:0], last: last};
			best_len = 1;
		end
		emit_token(r);
		window_bytes = (best_len >= 8) ? '0 : window_bytes >> (8 * best_len);
		window_count = (best_len >= window_count) ? 0 : window_count - best_len;
	endfunction

	function automatic void tokenize_item(input tok_item_t it);
		new_tokens.delete();
		if (it.kind == glmt_pkg::KIND_LOAD) begin
			slot_key[it.entry_index] = it.entry_bytes;
			slot_len[it.entry_index] = it.entry_length;
			slot_id[it.entry_index] = it.entry_id;
			return;
		end
		if (window_count < MAX_TOKEN_BYTES) begin
			window_bytes |= 64'(it.text_byte) << (8 * window_count);
			window_count++;
		end
		if (it.text_last) begin
			// drain the window, then close the text
			while (window_count > 0 && new_tokens.size() < MAX_TOKEN_BYTES)
				longest_match(1'b0);
			window_count = 0;
			window_bytes = '0;
			emit_token('{rkind: glmt_pkg::RK_END, id: 16'd0, skipped: 8'd0, last: 1'b1});
		end else if (window_count >= MAX_TOKEN_BYTES) begin
			longest_match(1'b1);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet_text)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit [7:0] letter();
		return 8'h61 + 8'($urandom_range(0, 3));
	endfunction

	function automatic tok_item_t random_load();
		tok_item_t it;
		int        r;
		it = $bits(tok_item_t)'({$urandom, $urandom, $urandom, $urandom});
		it.kind = glmt_pkg::KIND_LOAD;
		it.entry_index = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 31));
		r = $urandom_range(0, 99);
		if (r < 8)
			it.entry_length = 4'd0;
		else if (r < 16)
			it.entry_length = 4'($urandom_range(9, 15));
		else if (r < 30)
			it.entry_length = 4'($urandom_range(5, 8));
		else
			it.entry_length = 4'($urandom_range(1, 4));
		it.entry_bytes = {$urandom, $urandom};
		for (int j = 0; j < 8; j++)
			if (j < it.entry_length)
				it.entry_bytes[8*j +: 8] = letter();
		it.entry_id = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic tok_item_t random_text(input bit last, input bit noisy);
		tok_item_t it;
		it = $bits(tok_item_t)'({$urandom, $urandom, $urandom, $urandom});
		it.kind = glmt_pkg::KIND_TEXT;
		it.text_byte = (noisy || $urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: letter();
		it.text_last = last;
		return it;
	endfunction

	function automatic plan_row_t load_row(input bit [7:0] idx, input bit [63:0] key,
			input bit [3:0] len, input bit [15:0] id);
		plan_row_t r;
		r = '{default: '0};
		r.it = '0;
		r.it.kind = glmt_pkg::KIND_LOAD;
		r.it.entry_index = idx;
		r.it.entry_bytes = key;
		r.it.entry_length = len;
		r.it.entry_id = id;
		return r;
	endfunction

	function automatic plan_row_t text_row(input bit [7:0] b, input bit last);
		plan_row_t r;
		r = '{default: '0};
		r.it = '0;
		r.it.kind = glmt_pkg::KIND_TEXT;
		r.it.text_byte = b;
		r.it.text_last = last;
		return r;
	endfunction

	function automatic plan_row_t expecting(input plan_row_t r, input bit [1:0] rk,
			input bit [15:0] id, input bit [7:0] sk, input bit last);
		r.typed = 1'b1;
		r.typed_res[r.n_typed] = '{rkind: rk, id: id, skipped: sk, last: last};
		r.n_typed++;
		return r;
	endfunction

	task automatic note_fault(input string what);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	// Hold the transaction until ready; predict at the accepting edge.
	task automatic send_item(input tok_item_t it, input int gap, input bit typed);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.kind <= it.kind;
		text_ch.entry_index <= it.entry_index;
		text_ch.entry_bytes <= it.entry_bytes;
		text_ch.entry_length <= it.entry_length;
		text_ch.entry_id <= it.entry_id;
		text_ch.text_byte <= it.text_byte;
		text_ch.text_last <= it.text_last;
		@(posedge clk);
		while (text_ch.ready !== 1'b1)
			@(posedge clk);
		tokenize_item(it);
		if (it.kind == glmt_pkg::KIND_LOAD)
			loads_sent++;
		else
			bytes_sent++;
		if (!typed)
			foreach (new_tokens[k])
				expected_tokens = {expected_tokens, new_tokens[k]};
	endtask

	// receiver: ready held in runs, with calm stretches and occasional long stalls
	initial begin
		int hold;
		int r;
		bit level;
		bit calm;
		int phase_left;
		hold = 0;
		level = 1'b0;
		calm = 1'b0;
		phase_left = 0;
		token_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				phase_left = $urandom_range(300, 3000);
			end
			phase_left--;
			if (hold == 0) begin
				if (calm || $urandom_range(0, 2) != 0) begin
					level = 1'b1;
					hold = $urandom_range(1, 8);
				end else begin
					level = 1'b0;
					r = $urandom_range(0, 9);
					hold = (r < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
				end
			end
			hold--;
			token_ch.ready <= level;
		end
	end

	always @(posedge clk) begin
		token_t want;
		if (arst_n === 1'b1 && token_ch.valid === 1'b1 && token_ch.ready === 1'b1) begin
			results_seen++;
			case (token_ch.result_kind)
				glmt_pkg::RK_MATCH: matches_seen++;
				glmt_pkg::RK_SKIP:  skips_seen++;
				glmt_pkg::RK_END:   ends_seen++;
				default:  ;
			endcase
			if (expected_tokens.size() == 0) begin
				note_fault($sformatf("result %0d unexpected: kind %0d id %h byte %h last %0b",
					results_seen, token_ch.result_kind, token_ch.token_id,
					token_ch.skipped_byte, token_ch.last));
			end else begin
				want = expected_tokens.pop_front();
				if (token_ch.result_kind !== want.rkind || token_ch.token_id !== want.id ||
						token_ch.skipped_byte !== want.skipped || token_ch.last !== want.last)
					note_fault($sformatf({"result %0d: expected kind %0d id %h byte %h last %0b,",
						" got kind %0d id %h byte %h last %0b"}, results_seen,
						want.rkind, want.id, want.skipped, want.last,
						token_ch.result_kind, token_ch.token_id,
						token_ch.skipped_byte, token_ch.last));
			end
		end
	end

	// watchdog: count cycles without any transaction on either side
	always @(posedge clk) begin
		if ((text_ch.valid === 1'b1 && text_ch.ready === 1'b1) ||
				(token_ch.valid === 1'b1 && token_ch.ready === 1'b1))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles, %0d results outstanding",
				$realtime, stalled_cycles, expected_tokens.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		plan_row_t plan[$];
		int        n;
		int        text_len;
		bit        noisy;

		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.kind <= glmt_pkg::KIND_LOAD;
		text_ch.entry_index <= '0;
		text_ch.entry_bytes <= '0;
		text_ch.entry_length <= '0;
		text_ch.entry_id <= '0;
		text_ch.text_byte <= '0;
		text_ch.text_last <= 1'b0;
		quiet_text = 1'b0;

		// empty table after reset: the only byte is skipped
		plan = {plan, expecting(expecting(text_row(8'h41, 1'b1),
			glmt_pkg::RK_SKIP, 16'd0, 8'h41, 1'b0), glmt_pkg::RK_END, 16'd0, 8'd0, 1'b1)};
		plan = {plan, load_row(8'd0, 64'h0000_0000_0000_6261, 4'd2, 16'hFFFF)};
		// same key higher up, junk beyond the length
		plan = {plan, load_row(8'd255, 64'hFFFF_FFFF_FFFF_6261, 4'd2, 16'h0000)};
		plan = {plan, load_row(8'd1, 64'h0000_0000_0000_0061, 4'd1, 16'h0001)};
		plan = {plan, load_row(8'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 16'h8000)};
		// over-long key can never match
		plan = {plan, load_row(8'd3, 64'h0000_0000_0000_0000, 4'd15, 16'h1234)};
		plan = {plan, text_row(8'h61, 1'b0)};
		plan = {plan, expecting(expecting(text_row(8'h62, 1'b1),
			glmt_pkg::RK_MATCH, 16'hFFFF, 8'd0, 1'b0), glmt_pkg::RK_END, 16'd0, 8'd0, 1'b1)};
		plan = {plan, expecting(expecting(text_row(8'h00, 1'b1),
			glmt_pkg::RK_SKIP, 16'd0, 8'h00, 1'b0), glmt_pkg::RK_END, 16'd0, 8'd0, 1'b1)};
		for (int j = 0; j < 7; j++)
			plan = {plan, text_row(8'hFF, 1'b0)};
		plan = {plan, expecting(expecting(text_row(8'hFF, 1'b1),
			glmt_pkg::RK_MATCH, 16'h8000, 8'd0, 1'b0), glmt_pkg::RK_END, 16'd0, 8'd0, 1'b1)};
		// invalidate slot 0 so its duplicate takes over
		plan = {plan, load_row(8'd0, 64'h0000_0000_0000_6261, 4'd0, 16'hFFFF)};
		plan = {plan, text_row(8'h61, 1'b0)};
		plan = {plan, expecting(expecting(text_row(8'h62, 1'b1),
			glmt_pkg::RK_MATCH, 16'h0000, 8'd0, 1'b0), glmt_pkg::RK_END, 16'd0, 8'd0, 1'b1)};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			send_item(plan[r].it, pick_gap(), plan[r].typed);
			for (int k = 0; k < plan[r].n_typed; k++)
				expected_tokens = {expected_tokens, plan[r].typed_res[k]};
		end

		// seed the table with random loads, then alternate load bursts and texts
		repeat (24) send_item(random_load(), pick_gap(), 1'b0);
		while (loads_sent + bytes_sent < ITEM_TARGET) begin
			quiet_text = ($urandom_range(0, 5) == 0);
			n = $urandom_range(0, 3);
			repeat (n) send_item(random_load(), pick_gap(), 1'b0);
			noisy = ($urandom_range(0, 7) == 0);
			text_len = ($urandom_range(0, 2) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			for (int j = 0; j < text_len; j++) begin
				if ($urandom_range(0, 24) == 0)
					send_item(random_load(), pick_gap(), 1'b0);
				send_item(random_text(j == text_len - 1, noisy), pick_gap(), 1'b0);
			end
		end
		text_ch.valid <= 1'b0;

		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (TABLE_ENTRIES + 16) @(posedge clk);

		$display("Sent %0d table loads and %0d text bytes.", loads_sent, bytes_sent);
		$display("Received %0d matches, %0d skipped bytes and %0d text ends; %0d mismatches.",
			matches_seen, skips_seen, ends_seen, fault_count);
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
